[design/ptw_pkg.sv]
`default_nettype none

package ptw_pkg;

  localparam int unsigned VaWidth    = 39;
  localparam int unsigned PteWidth   = 64;
  localparam int unsigned PaWidth    = 56;
  localparam int unsigned PpnWidth   = 44;
  localparam int unsigned IdxWidth   = 9;
  localparam int unsigned VpnWidth   = 27;
  localparam int unsigned PageShift  = 12;
  localparam int unsigned PteShift   = 3;
  localparam int unsigned PpnLsb     = 10;
  localparam int unsigned PteValidBit = 0;
  localparam int unsigned PteUserBit  = 4;

  localparam logic CMD_TRANSLATE = 1'b0;
  localparam logic CMD_RESPONSE  = 1'b1;

  localparam logic KIND_MEM_REQ = 1'b0;
  localparam logic KIND_DONE    = 1'b1;

  localparam logic [1:0] LEVEL_0 = 2'd0;
  localparam logic [1:0] LEVEL_1 = 2'd1;
  localparam logic [1:0] LEVEL_2 = 2'd2;

  localparam logic REG_ROOT_PPN   = 1'b0;
  localparam logic REG_USER_CHECK = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FAULT = 2'd1,
    STATUS_PROTO = 2'd2
  } status_e;

  typedef struct packed {
    logic       load_va;
    logic       load_out;
    logic       use_root;
    logic [1:0] idx_level;
    logic       kind;
    status_e    status;
    logic       pa_en;
  } ptw_cmd_t;

  typedef struct packed {
    logic out_valid;
    logic va_high;
    logic pte_valid;
    logic pte_user_ok;
  } ptw_sts_t;

endpackage

`default_nettype wire

[design/ptw_ctrl.sv]
`default_nettype none

module ptw_ctrl
  import ptw_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire logic     cmd_i,
  input  wire logic     out_ready_i,
  input  wire ptw_sts_t sts_i,
  output ptw_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_L2   = 4'b0010,
    ST_L1   = 4'b0100,
    ST_L0   = 4'b1000
  } walk_state_e;

  walk_state_e state_q, state_d;
  logic        fire;

  // A new item may enter whenever the output register is empty or drains now.
  assign in_ready_o = !sts_i.out_valid || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.load_out  = fire;
    cmd_o.kind      = KIND_DONE;
    cmd_o.status    = STATUS_PROTO;
    cmd_o.idx_level = LEVEL_2;
    if (fire) begin
      if (cmd_i == CMD_TRANSLATE) begin
        if (state_q != ST_IDLE) begin
          cmd_o.status = STATUS_PROTO;
        end else if (sts_i.va_high) begin
          cmd_o.status = STATUS_FAULT;
        end else begin
          cmd_o.load_va   = 1'b1;
          cmd_o.use_root  = 1'b1;
          cmd_o.idx_level = LEVEL_2;
          cmd_o.kind      = KIND_MEM_REQ;
          cmd_o.status    = STATUS_OK;
          state_d         = ST_L2;
        end
      end else begin
        case (state_q)
          ST_IDLE: begin
            cmd_o.status = STATUS_PROTO;
          end
          ST_L2, ST_L1: begin
            if (!sts_i.pte_valid) begin
              cmd_o.status = STATUS_FAULT;
              state_d      = ST_IDLE;
            end else begin
              cmd_o.kind      = KIND_MEM_REQ;
              cmd_o.status    = STATUS_OK;
              cmd_o.idx_level = (state_q == ST_L2) ? LEVEL_1 : LEVEL_0;
              state_d         = (state_q == ST_L2) ? ST_L1 : ST_L0;
            end
          end
          ST_L0: begin
            state_d = ST_IDLE;
            if (!sts_i.pte_valid || !sts_i.pte_user_ok) begin
              cmd_o.status = STATUS_FAULT;
            end else begin
              cmd_o.status = STATUS_OK;
              cmd_o.pa_en  = 1'b1;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[design/ptw_dpath.sv]
`default_nettype none

module ptw_dpath
  import ptw_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_index_i,
  input  wire logic [PpnWidth-1:0]   cfg_wdata_i,
  input  wire logic [VaWidth-1:0]    va_i,
  input  wire logic [PteWidth-1:0]   read_data_i,
  input  wire logic                  out_ready_i,
  input  wire ptw_cmd_t              cmd_i,
  output ptw_sts_t                   sts_o,
  output logic                       out_valid_o,
  output logic                       kind_o,
  output logic [PaWidth-1:0]         mem_addr_o,
  output logic [1:0]                 status_o,
  output logic [PaWidth-1:0]         pa_o
);

  logic [PpnWidth-1:0] root_ppn_q;
  logic                user_check_q;
  logic [VpnWidth-1:0] vpn_q;
  logic                out_valid_q, out_valid_d;
  logic                kind_q;
  logic [PaWidth-1:0]  mem_addr_q, mem_addr_d;
  status_e             status_q;
  logic [PaWidth-1:0]  pa_q, pa_d;
  logic [PpnWidth-1:0] pte_ppn;
  logic [PpnWidth-1:0] base_ppn;
  logic [IdxWidth-1:0] idx;

  assign pte_ppn = read_data_i[PpnLsb +: PpnWidth];

  assign sts_o.out_valid   = out_valid_q;
  assign sts_o.va_high     = va_i[VaWidth-1];
  assign sts_o.pte_valid   = read_data_i[PteValidBit];
  assign sts_o.pte_user_ok = !user_check_q || read_data_i[PteUserBit];

  always_comb begin
    base_ppn = cmd_i.use_root ? root_ppn_q : pte_ppn;
    case (cmd_i.idx_level)
      LEVEL_0: idx = vpn_q[0 +: IdxWidth];
      LEVEL_1: idx = vpn_q[IdxWidth +: IdxWidth];
      default: idx = vpn_q[2*IdxWidth +: IdxWidth];
    endcase
    // The first read uses the index of the address arriving in this transfer.
    if (cmd_i.use_root) begin
      idx = va_i[PageShift + 2*IdxWidth +: IdxWidth];
    end
    mem_addr_d = (cmd_i.kind == KIND_MEM_REQ) ? {base_ppn, idx, {PteShift{1'b0}}} : '0;
    pa_d       = cmd_i.pa_en ? {pte_ppn, {PageShift{1'b0}}} : '0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_ppn_q   <= '0;
      user_check_q <= 1'b1;
      vpn_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_index_i == REG_ROOT_PPN) begin
          root_ppn_q <= cfg_wdata_i;
        end else begin
          user_check_q <= cfg_wdata_i[0];
        end
      end
      if (cmd_i.load_va) begin
        vpn_q <= va_i[PageShift +: VpnWidth];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      kind_q     <= cmd_i.kind;
      mem_addr_q <= mem_addr_d;
      status_q   <= cmd_i.status;
      pa_q       <= pa_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign mem_addr_o  = mem_addr_q;
  assign status_o    = status_q;
  assign pa_o        = pa_q;

endmodule

`default_nettype wire

[design/three_level_page_table_walker_core.sv]
// Sv39 page table walker.
// Input channel (in_valid_i/in_ready_o) carries either a translate request
// (cmd_i = 0, va_i) or a memory response carrying one page table entry
// (cmd_i = 1, read_data_i). Every input transfer yields exactly one result
// on the output channel (out_valid_o/out_ready_i): either a read request for
// the next entry (kind_o = 0, mem_addr_o) or a finished translation
// (kind_o = 1, status_o, pa_o).
// Each item is decoded in the cycle it is accepted and its result appears in
// the output register in the cycle after; one item per cycle is sustained
// while results are taken; a full walk takes three memory round trips.
// The input stays ready while the output register is empty or being drained
// in the same cycle; when the receiver stalls, the held result blocks further
// input until it is taken.
// Configuration writes (cfg_we_i, cfg_index_i: 0 root page number,
// 1 user-bit check enable) take effect at the next clock edge and are meant
// for idle periods. Reset leaves the walker idle with root page number 0 and
// the user-bit check enabled.
`default_nettype none

module three_level_page_table_walker_core
  import ptw_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_index_i,
  input  wire logic [PpnWidth-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                cmd_i,
  input  wire logic [VaWidth-1:0]  va_i,
  input  wire logic [PteWidth-1:0] read_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     kind_o,
  output logic [PaWidth-1:0]       mem_addr_o,
  output logic [1:0]               status_o,
  output logic [PaWidth-1:0]       pa_o
);

  ptw_cmd_t ctrl_cmd;
  ptw_sts_t dp_sts;

  ptw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .out_ready_i (out_ready_i),
    .sts_i       (dp_sts),
    .cmd_o       (ctrl_cmd)
  );

  ptw_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .va_i        (va_i),
    .read_data_i (read_data_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (ctrl_cmd),
    .sts_o       (dp_sts),
    .out_valid_o (out_valid_o),
    .kind_o      (kind_o),
    .mem_addr_o  (mem_addr_o),
    .status_o    (status_o),
    .pa_o        (pa_o)
  );

endmodule

`default_nettype wire
